>>> rtl/stepper_speed_ramp_period_top_assert.svh
// Assertion macros for the stepper speed ramp checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STEPPER_SPEED_RAMP_PERIOD_TOP_ASSERT_SVH
`define STEPPER_SPEED_RAMP_PERIOD_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ssrp_pkg.sv
// Shared types and constants for the stepper speed ramp and step period block.
// No dependencies; used by the divider, the top level and the checker.
package ssrp_pkg;

  localparam int DEN_W       = 35;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 56;
  localparam int ELAPSED_CAP = 1000;
  localparam int MS_PER_S    = 1000;
  localparam int SPEED_MAX   = 32767;

  localparam int OFS_DIR     = 0;
  localparam int OFS_VALID   = 1;
  localparam int OFS_PERIOD  = 2;
  localparam int OFS_COMPARE = 18;
  localparam int OFS_SPEED   = 33;
  localparam int OFS_START   = 48;
  localparam int OFS_STOP    = 49;
  localparam int OFS_RUN     = 50;

  localparam logic [2:0] REG_FULL_STEPS = 3'd0;
  localparam logic [2:0] REG_MICROSTEPS = 3'd1;
  localparam logic [2:0] REG_ACCEL      = 3'd2;
  localparam logic [2:0] REG_TICK_MS    = 3'd3;
  localparam logic [2:0] REG_INVERT     = 3'd4;

  typedef struct packed {
    logic        running;
    logic        timer_stop;
    logic        timer_start;
    logic [14:0] ramped_speed_mrps;
    logic [14:0] compare_ticks;
    logic [15:0] step_period;
    logic        period_valid;
    logic        direction_level;
  } result_t;

  function automatic logic [M_TDATA_W-1:0] pack_result(input result_t r);
    pack_result = M_TDATA_W'(r);
  endfunction

endpackage

>>> rtl/ssrp_div.sv
// Radix-4 restoring divider, two quotient bits per cycle from a shift register.
// Depends on ssrp_pkg for the divisor width.
module ssrp_div #(
  parameter int DW = 34
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [ssrp_pkg::DEN_W-1:0] divisor,
  output logic                       done,
  output logic [DW-1:0]              quotient
);

  localparam int NS = (DW + 1) / 2;
  localparam int QW = 2 * NS;
  localparam int CW = $clog2(NS + 1);

  logic [ssrp_pkg::DEN_W-1:0] rem;
  logic [ssrp_pkg::DEN_W-1:0] dsr;
  logic [QW-1:0]              qsr;
  logic [CW-1:0]              cnt;
  logic                       busy;

  logic [ssrp_pkg::DEN_W-1:0] rem_next;
  logic [QW-1:0]              qsr_next;
  logic [ssrp_pkg::DEN_W:0]   trial;

  always_comb begin
    rem_next = rem;
    qsr_next = qsr;
    trial    = '0;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_next, qsr_next[QW-1]};
      qsr_next = {qsr_next[QW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial       = trial - {1'b0, dsr};
        qsr_next[0] = 1'b1;
      end
      rem_next = trial[ssrp_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        qsr  <= QW'(dividend);
        dsr  <= divisor;
        cnt  <= CW'(NS);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        qsr <= qsr_next;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = qsr[DW-1:0];

endmodule

>>> rtl/stepper_speed_ramp_period_top.sv
// Stepper speed ramp and step period generator, one instance per motor. Each request carries a
// signed target speed and a tick count; the block ramps its stored speed toward a nonzero target
// under the acceleration limit, or drops it to zero at once for a zero target, and returns one
// result with the direction level, the step period, the half-period compare value and the timer
// start and stop flags. One request is worked at a time: the next request is taken only once the
// result has been written to the output register, which waits while a stalled result is held.
// A zero target skips the divider; otherwise the shared radix-4 divider is used once for the
// acceleration step and once for the period. A finished result waits in the output register
// while the next request is taken. Depends on ssrp_pkg, ssrp_div.
module stepper_speed_ramp_period_top #(
  parameter int TIMER_CLOCK_HZ   = 10000000,
  parameter int MIN_PERIOD_TICKS = 10,
  parameter int MAX_PERIOD_TICKS = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] target_speed_mrps, [47:16] now_tick
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] direction_level, [1] period_valid, [17:2] step_period, [32:18] compare_ticks,
  // [47:33] ramped_speed_mrps, [48] timer_start, [49] timer_stop, [50] running, [55:51] zero
  output logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam longint DIVIDEND = longint'(TIMER_CLOCK_HZ) * 1000;
  localparam int     DW       = $clog2(DIVIDEND + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ELAP = 8'b0000_0010,
    S_MCH  = 8'b0000_0100,
    S_WMC  = 8'b0000_1000,
    S_DEN1 = 8'b0001_0000,
    S_DEN2 = 8'b0010_0000,
    S_WPER = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [10:0] steps_rev;
  logic [8:0]  microsteps;
  logic [19:0] accel;
  logic [9:0]  tick_ms;
  logic        invert;

  logic [14:0] speed;
  logic [31:0] prev_tick;
  logic        timer_running;

  logic [14:0] target;
  logic        diff_big;
  logic [9:0]  diff_small;
  logic [9:0]  elapsed;
  logic [25:0] den_part;
  ssrp_pkg::result_t res;

  logic [15:0] raw_mag;
  logic [14:0] target_in;
  logic [31:0] diff;
  logic [19:0] elapsed_prod;
  logic [14:0] speed_floor;
  logic [DW:0] cur_ext;
  logic [DW:0] tgt_ext;
  logic [DW:0] mc_ext;
  logic [15:0] period;

  logic                       div_start;
  logic [DW-1:0]              div_dividend;
  logic [ssrp_pkg::DEN_W-1:0] div_divisor;
  logic                       div_done;
  logic [DW-1:0]              div_quotient;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign s_tready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_rev  <= 11'd200;
      microsteps <= 9'd16;
      accel      <= 20'd10000;
      tick_ms    <= 10'd10;
      invert     <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        ssrp_pkg::REG_FULL_STEPS: steps_rev  <= pwdata[10:0];
        ssrp_pkg::REG_MICROSTEPS: microsteps <= pwdata[8:0];
        ssrp_pkg::REG_ACCEL:      accel      <= pwdata[19:0];
        ssrp_pkg::REG_TICK_MS:    tick_ms    <= pwdata[9:0];
        ssrp_pkg::REG_INVERT:     invert     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ssrp_pkg::REG_FULL_STEPS: prdata = 32'(steps_rev);
      ssrp_pkg::REG_MICROSTEPS: prdata = 32'(microsteps);
      ssrp_pkg::REG_ACCEL:      prdata = 32'(accel);
      ssrp_pkg::REG_TICK_MS:    prdata = 32'(tick_ms);
      ssrp_pkg::REG_INVERT:     prdata = 32'(invert);
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    raw_mag      = s_tdata[15] ? (16'd0 - s_tdata[15:0]) : s_tdata[15:0];
    target_in    = (raw_mag > 16'(ssrp_pkg::SPEED_MAX)) ? 15'(ssrp_pkg::SPEED_MAX)
                                                        : raw_mag[14:0];
    diff         = s_tdata[47:16] - prev_tick;
    elapsed_prod = 20'(diff_small) * 20'(tick_ms);
    speed_floor  = (speed == 15'd0) ? 15'd1 : speed;
    cur_ext      = (DW + 1)'(speed);
    tgt_ext      = (DW + 1)'(target);
    mc_ext       = (DW + 1)'(div_quotient);
    if (div_quotient < DW'(MIN_PERIOD_TICKS)) begin
      period = 16'(MIN_PERIOD_TICKS);
    end else if (div_quotient > DW'(MAX_PERIOD_TICKS)) begin
      period = 16'(MAX_PERIOD_TICKS);
    end else begin
      period = div_quotient[15:0];
    end
  end

  assign div_start    = (state == S_MCH) || (state == S_DEN2);
  assign div_dividend = (state == S_MCH) ? DW'(30'(accel) * 30'(elapsed)) : DW'(DIVIDEND);
  assign div_divisor  = (state == S_MCH) ? ssrp_pkg::DEN_W'(ssrp_pkg::MS_PER_S)
                                         : ssrp_pkg::DEN_W'(35'(den_part) * 35'(microsteps));

  ssrp_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      speed         <= '0;
      prev_tick     <= '0;
      timer_running <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            target              <= target_in;
            diff_big            <= (diff > 32'(ssrp_pkg::ELAPSED_CAP));
            diff_small          <= diff[9:0];
            res.direction_level <= ~s_tdata[15] ^ invert;
            res.period_valid    <= 1'b0;
            res.step_period     <= '0;
            res.compare_ticks   <= '0;
            res.timer_start     <= 1'b0;
            if (target_in == 15'd0) begin
              res.timer_stop        <= timer_running;
              res.running           <= 1'b0;
              res.ramped_speed_mrps <= '0;
              timer_running         <= 1'b0;
              speed                 <= '0;
              state                 <= S_FIN;
            end else begin
              res.timer_stop <= 1'b0;
              prev_tick      <= s_tdata[47:16];
              state          <= S_ELAP;
            end
          end
        end
        S_ELAP: begin
          if (tick_ms == 10'd0) begin
            elapsed <= '0;
          end else if (diff_big || (elapsed_prod > 20'(ssrp_pkg::ELAPSED_CAP))) begin
            elapsed <= 10'(ssrp_pkg::ELAPSED_CAP);
          end else begin
            elapsed <= elapsed_prod[9:0];
          end
          state <= S_MCH;
        end
        S_MCH: begin
          state <= S_WMC;
        end
        S_WMC: begin
          if (div_done) begin
            if (tgt_ext > cur_ext + mc_ext) begin
              speed <= 15'(cur_ext + mc_ext);
            end else if (tgt_ext + mc_ext < cur_ext) begin
              speed <= 15'(cur_ext - mc_ext);
            end else begin
              speed <= target;
            end
            state <= S_DEN1;
          end
        end
        S_DEN1: begin
          den_part <= 26'(speed_floor) * 26'(steps_rev);
          state    <= S_DEN2;
        end
        S_DEN2: begin
          state <= S_WPER;
        end
        S_WPER: begin
          if (div_done) begin
            res.period_valid      <= 1'b1;
            res.step_period       <= period;
            res.compare_ticks     <= period[15:1];
            res.ramped_speed_mrps <= speed;
            res.timer_start       <= ~timer_running;
            res.running           <= 1'b1;
            timer_running         <= 1'b1;
            state                 <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= ssrp_pkg::pack_result(res);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/ssrp_checker.sv
// Port-level checker for the stepper speed ramp block, bound to the top level.
// Depends on ssrp_pkg and the assertion macros header.
`include "stepper_speed_ramp_period_top_assert.svh"

module ssrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  `SSRP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stalled result changed")
  `SSRP_ASSERT_NOW(a_no_period, m_tvalid && !m_tdata[ssrp_pkg::OFS_VALID], m_tdata[ssrp_pkg::OFS_PERIOD +: 31] == 31'd0, "Period given without a valid flag")
  `SSRP_ASSERT_NOW(a_compare_half, m_tvalid && m_tdata[ssrp_pkg::OFS_VALID], m_tdata[ssrp_pkg::OFS_COMPARE +: 15] == m_tdata[ssrp_pkg::OFS_PERIOD + 1 +: 15], "Compare value is not half the period")
  `SSRP_ASSERT_NOW(a_start, m_tvalid && m_tdata[ssrp_pkg::OFS_START], m_tdata[ssrp_pkg::OFS_RUN] && m_tdata[ssrp_pkg::OFS_VALID] && !m_tdata[ssrp_pkg::OFS_STOP], "Timer start without a running period")
  `SSRP_ASSERT_NOW(a_stop, m_tvalid && m_tdata[ssrp_pkg::OFS_STOP], !m_tdata[ssrp_pkg::OFS_RUN] && !m_tdata[ssrp_pkg::OFS_VALID] && m_tdata[ssrp_pkg::OFS_SPEED +: 15] == 15'd0, "Timer stop left the motor running")

endmodule

bind stepper_speed_ramp_period_top ssrp_checker u_ssrp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
